// ----- hw/rtl/bpd_pkg.sv -----
// Shared types and codes for the bounded position deque.
// No dependencies; used by every file in hw/rtl.
package bpd_pkg;

	localparam int DEFAULT_CAPACITY = 256;

	// request codes (req_type)
	localparam logic [2:0] OP_INS_HEAD = 3'd0;
	localparam logic [2:0] OP_INS_TAIL = 3'd1;
	localparam logic [2:0] OP_REM_HEAD = 3'd2;
	localparam logic [2:0] OP_REM_TAIL = 3'd3;
	localparam logic [2:0] OP_RD_HEAD  = 3'd4;
	localparam logic [2:0] OP_RD_TAIL  = 3'd5;
	localparam logic [2:0] OP_RD_INDEX = 3'd6;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_OUT_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] in_x;
		logic [7:0] in_y;
		logic [7:0] in_symbol;
		logic [7:0] read_index;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       read_valid;
		logic [7:0] out_x;
		logic [7:0] out_y;
		logic [7:0] out_symbol;
		logic [8:0] list_count;
	} rsp_item_t;

	// one stored entry: symbol, y, x
	typedef struct packed {
		logic [7:0] symbol;
		logic [7:0] y;
		logic [7:0] x;
	} entry_t;

	// per-item result info that travels alongside the memory read
	typedef struct packed {
		logic [1:0] status;
		logic       read_valid;
		logic [8:0] list_count;
	} rsp_info_t;

endpackage

// ----- hw/rtl/bpd_store.sv -----
// Entry store: single-port synchronous RAM with a registered read.
// Depends on bpd_pkg (entry_t).
module bpd_store #(
	parameter int CAPACITY = bpd_pkg::DEFAULT_CAPACITY,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [AW-1:0]     addr,
	input  bpd_pkg::entry_t   wdata,
	output bpd_pkg::entry_t   rdata
);

	bpd_pkg::entry_t mem [CAPACITY];
	bpd_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		// read data holds until the next read, so a stalled item keeps it
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bpd_ctrl.sv -----
// Deque control: head pointer, fill count, slot arithmetic, stage-1 info.
// Depends on bpd_pkg; drives the bpd_store port.
module bpd_ctrl #(
	parameter int CAPACITY = bpd_pkg::DEFAULT_CAPACITY,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int SW = AW + 1,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int IW = (CW > 8) ? CW : 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  bpd_pkg::req_item_t    req,
	input  logic                  adv_s1,
	output logic                  mem_we,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_addr,
	output bpd_pkg::entry_t       mem_wdata,
	output logic                  valid_s1,
	output bpd_pkg::rsp_info_t    info_s1
);

	logic [AW-1:0] head_q, head_nxt, head_dec, head_inc;
	logic [CW-1:0] count_q, count_nxt, count_m1;
	logic          full, empty;
	logic [AW-1:0] pos, slot;
	logic [SW-1:0] slot_sum;
	logic [1:0]    status;
	logic          rd_hit;
	logic          wr_head;
	logic          valid_s1_q;
	bpd_pkg::rsp_info_t info_s1_q;

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CW'(1);
	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);

	// both operands below CAPACITY, so one conditional subtract wraps it
	assign slot_sum = {1'b0, head_q} + {1'b0, pos};
	assign slot = (slot_sum >= SW'(CAPACITY)) ? AW'(slot_sum - SW'(CAPACITY))
	                                          : slot_sum[AW-1:0];

	always_comb begin
		status    = bpd_pkg::ST_OK;
		rd_hit    = 1'b0;
		mem_we    = 1'b0;
		wr_head   = 1'b0;
		pos       = '0;
		head_nxt  = head_q;
		count_nxt = count_q;
		case (req.req_type)
			bpd_pkg::OP_INS_HEAD, bpd_pkg::OP_INS_TAIL: begin
				if (full) begin
					status = bpd_pkg::ST_FULL;
				end else begin
					mem_we    = 1'b1;
					count_nxt = count_q + CW'(1);
					pos       = count_q[AW-1:0];
					if (req.req_type == bpd_pkg::OP_INS_HEAD) begin
						wr_head  = 1'b1;
						head_nxt = head_dec;
					end
				end
			end
			bpd_pkg::OP_REM_HEAD, bpd_pkg::OP_REM_TAIL: begin
				if (empty) begin
					status = bpd_pkg::ST_EMPTY;
				end else begin
					count_nxt = count_m1;
					if (req.req_type == bpd_pkg::OP_REM_HEAD) begin
						head_nxt = head_inc;
					end
				end
			end
			bpd_pkg::OP_RD_HEAD, bpd_pkg::OP_RD_TAIL: begin
				if (empty) begin
					status = bpd_pkg::ST_EMPTY;
				end else begin
					rd_hit = 1'b1;
					if (req.req_type == bpd_pkg::OP_RD_TAIL) begin
						pos = count_m1[AW-1:0];
					end
				end
			end
			bpd_pkg::OP_RD_INDEX: begin
				if (empty) begin
					status = bpd_pkg::ST_EMPTY;
				end else if (IW'(req.read_index) >= IW'(count_q)) begin
					status = bpd_pkg::ST_OUT_RANGE;
				end else begin
					rd_hit = 1'b1;
					pos    = AW'(IW'(req.read_index));
				end
			end
			default: begin
				// unused code: no change, ok status
			end
		endcase
	end

	// write enable is only meaningful with accept; qualified at the top
	assign mem_re    = accept && rd_hit;
	assign mem_addr  = wr_head ? head_dec : slot;
	assign mem_wdata = '{symbol: req.in_symbol, y: req.in_y, x: req.in_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			valid_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q     <= head_nxt;
				count_q    <= count_nxt;
				valid_s1_q <= 1'b1;
			end else if (adv_s1) begin
				valid_s1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1_q <= '{status: status, read_valid: rd_hit,
			               list_count: 9'(count_nxt)};
		end
	end

	assign valid_s1 = valid_s1_q;
	assign info_s1  = info_s1_q;

endmodule

// ----- hw/rtl/bounded_position_deque.sv -----
// Top level of the bounded position deque: control, entry RAM, result register.
// Depends on bpd_pkg, bpd_ctrl and bpd_store.
//
// Usage:
//   Requests arrive on req (req_valid/req_ready); each accepted item yields
//   exactly one result item on rsp (rsp_valid/rsp_ready), in order.
//   Each request inserts at head or tail, removes head or tail, or reads the
//   head, the tail or an entry by list position; list_count in every result
//   is the size after that request.
// Timing:
//   An accepted item passes through the entry RAM's registered read and then
//   the result register before its result is valid. One item per cycle is
//   sustained while rsp_ready is high; the head pointer and count update at
//   acceptance, and a write reaches the RAM before the next read.
// Reset:
//   arst_n clears the head pointer, the count and all valid flags. The RAM
//   is not cleared: only entries inside the list are ever read.
// Stall:
//   With rsp_ready low the result register holds its item, stage 1 can
//   still hold one more, and req_ready drops once both are occupied.
module bounded_position_deque #(
	parameter int CAPACITY = bpd_pkg::DEFAULT_CAPACITY,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bpd_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output bpd_pkg::rsp_item_t  rsp
);

	logic               accept;
	logic               adv_s1;
	logic               valid_s1;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_addr;
	bpd_pkg::entry_t    mem_wdata, mem_rdata;
	bpd_pkg::rsp_info_t info_s1;
	logic               rsp_valid_q;
	bpd_pkg::rsp_item_t rsp_q;

	// stage 1 moves on when the result register is empty or being drained
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;
	assign accept    = req_valid && req_ready;

	bpd_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.adv_s1    (adv_s1),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.valid_s1  (valid_s1),
		.info_s1   (info_s1)
	);

	bpd_store #(.CAPACITY(CAPACITY)) u_store (
		.clk   (clk),
		.we    (accept && mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// read fields are zero unless the item read a real entry
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.status     <= info_s1.status;
			rsp_q.read_valid <= info_s1.read_valid;
			rsp_q.list_count <= info_s1.list_count;
			rsp_q.out_x      <= info_s1.read_valid ? mem_rdata.x : 8'd0;
			rsp_q.out_y      <= info_s1.read_valid ? mem_rdata.y : 8'd0;
			rsp_q.out_symbol <= info_s1.read_valid ? mem_rdata.symbol : 8'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/bpd_checker.sv -----
// Port-level checks for the bounded position deque, bound to the top level.
// Depends on bpd_pkg and bounded_position_deque.
module bpd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input bpd_pkg::req_item_t req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input bpd_pkg::rsp_item_t rsp
);

	// a waiting request keeps its valid and its payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// a stalled result keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// read fields are zero when nothing was read
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.read_valid |->
			rsp.out_x == 8'd0 && rsp.out_y == 8'd0 && rsp.out_symbol == 8'd0)
		else $error("read fields not zero without a read");

	// a real read always reports ok
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_valid |-> rsp.status == bpd_pkg::ST_OK)
		else $error("read result with error status");

	// an out of range result never carries an entry
	a_range_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bpd_pkg::ST_OUT_RANGE |-> !rsp.read_valid)
		else $error("out of range result marked valid");

endmodule

bind bounded_position_deque bpd_checker u_bpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
